// ===== hw/rtl/vrq_pkg.sv =====
// Shared constants, codes and types of the variable record ring queue.
// No dependencies; every other file of the block takes names from here.
`default_nettype none

package vrq_pkg;

  localparam int RING_DEPTH_DEFAULT = 1024;

  localparam int REQ_W    = 2;
  localparam int ID_W     = 16;
  localparam int LEN_W    = 16;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int BW_W     = 11;
  // A record of up to 65535 bytes takes at most 16385 words, header included.
  localparam int SIZE_W   = 15;

  localparam logic [BW_W-1:0] BUFFER_WORDS_RESET = 11'd1024;

  localparam logic [REQ_W-1:0] REQ_PUSH_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_DATA  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP        = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SEQ_ERR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

  // Outcome of the space check for a push start.
  typedef struct packed {
    logic reject;
    logic wrap;
  } place_t;

  // Payload words of a record: the byte length rounded up to whole words.
  function automatic logic [SIZE_W-1:0] payload_words(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] rounded;
    rounded = {1'b0, len} + (LEN_W + 1)'(3);
    return rounded[LEN_W:2];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vrq_if.sv =====
// Channel interfaces of the variable record ring queue: request, result, config.
// Depends on vrq_pkg for the field widths.
`default_nettype none

interface vrq_req_if;
  logic                        valid;
  logic                        ready;
  logic [vrq_pkg::REQ_W-1:0]   req_type;
  logic [vrq_pkg::ID_W-1:0]    identifier;
  logic [vrq_pkg::LEN_W-1:0]   byte_length;
  logic [vrq_pkg::WORD_W-1:0]  data_word;
  logic [vrq_pkg::LEN_W-1:0]   pop_capacity;

  modport source (output valid, req_type, identifier, byte_length, data_word, pop_capacity,
                  input ready);
  modport sink   (input valid, req_type, identifier, byte_length, data_word, pop_capacity,
                  output ready);
endinterface

interface vrq_res_if;
  logic                          valid;
  logic                          ready;
  logic [vrq_pkg::STATUS_W-1:0]  status;
  logic [vrq_pkg::ID_W-1:0]      out_identifier;
  logic [vrq_pkg::LEN_W-1:0]     out_length;
  logic [vrq_pkg::WORD_W-1:0]    out_word;
  logic                          first_of_record;
  logic                          last_of_record;
  logic [vrq_pkg::COUNT_W-1:0]   words_used;
  logic [vrq_pkg::COUNT_W-1:0]   records_stored;

  modport source (output valid, status, out_identifier, out_length, out_word,
                  first_of_record, last_of_record, words_used, records_stored,
                  input ready);
  modport sink   (input valid, status, out_identifier, out_length, out_word,
                  first_of_record, last_of_record, words_used, records_stored,
                  output ready);
endinterface

interface vrq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [vrq_pkg::BW_W-1:0]   buffer_words;

  modport source (output valid, buffer_words, input ready);
  modport sink   (input valid, buffer_words, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vrq_space_check.sv =====
// Space check for a push start: occupancy, wrap and behind-reader rules.
// Depends on vrq_pkg for widths and the place_t result type.
`default_nettype none

module vrq_space_check #(
  parameter int RING_DEPTH = vrq_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic [$clog2(RING_DEPTH+1)-1:0] insert_position,
  input  wire logic [$clog2(RING_DEPTH+1)-1:0] end_mark,
  input  wire logic [$clog2(RING_DEPTH+1)-1:0] read_position,
  input  wire logic [$clog2(RING_DEPTH+1)-1:0] occupied_words,
  input  wire logic [vrq_pkg::BW_W-1:0]        buffer_words,
  input  wire logic [vrq_pkg::SIZE_W-1:0]      size,
  output vrq_pkg::place_t                      place
);

  localparam int POS_W = $clog2(RING_DEPTH + 1);
  localparam int W_A   = (POS_W > vrq_pkg::SIZE_W) ? POS_W : vrq_pkg::SIZE_W;
  localparam int CMP_W = ((W_A > vrq_pkg::BW_W) ? W_A : vrq_pkg::BW_W) + 1;

  logic [CMP_W-1:0] bw;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] size_c;
  logic [CMP_W-1:0] insert_c;
  logic [CMP_W-1:0] end_c;
  logic [CMP_W-1:0] read_c;
  logic [CMP_W-1:0] occ_c;

  always_comb begin
    bw       = CMP_W'(buffer_words);
    size_c   = CMP_W'(size);
    insert_c = CMP_W'(insert_position);
    end_c    = CMP_W'(end_mark);
    read_c   = CMP_W'(read_position);
    occ_c    = CMP_W'(occupied_words);

    // The register is used clamped to two words and the memory depth.
    if (bw < CMP_W'(2)) begin
      limit = CMP_W'(2);
    end else if (bw > CMP_W'(RING_DEPTH)) begin
      limit = CMP_W'(RING_DEPTH);
    end else begin
      limit = bw;
    end

    place = '0;
    if (occ_c + size_c > limit) begin
      place.reject = 1'b1;
    end else if ((insert_c == end_c) && (insert_c + size_c > limit)) begin
      // No room before the wrap: restart at word zero if the reader is far enough on.
      place.wrap   = (read_c >= size_c);
      place.reject = (read_c < size_c);
    end else if ((insert_c < end_c) && (insert_c + size_c > read_c)) begin
      place.reject = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/variable_record_ring_queue.sv =====
// Variable record ring queue: top level with the ring memory and pointer logic.
// Depends on vrq_pkg, the channel interfaces in vrq_if and vrq_space_check.
// A result is registered once the ring read for its request beat has returned and
// no earlier result still waits for the sink. A new request is taken only once the
// previous one has executed, as the read of the ring memory comes before each
// pointer update and write back.
// Reset clears pointers, counters and both channels at once and sets buffer_words
// to 1024; the ring memory is not cleared, since no read reaches an unwritten word.
`default_nettype none

module variable_record_ring_queue #(
  parameter int RING_DEPTH = vrq_pkg::RING_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  vrq_req_if.sink   request,
  vrq_res_if.source result,
  vrq_cfg_if.sink   cfg
);

  // Positions run from zero up to and including the depth; memory addresses
  // fold a position of the depth itself back to word zero.
  localparam int POS_W  = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W = $clog2(RING_DEPTH);

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] folded;
    folded = (pos >= POS_W'(RING_DEPTH)) ? pos - POS_W'(RING_DEPTH) : pos;
    return folded[ADDR_W-1:0];
  endfunction

  // Configuration register. Users must write it only while the block is idle; the block does not enforce this.
  logic [vrq_pkg::BW_W-1:0] buffer_words;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_words <= vrq_pkg::BUFFER_WORDS_RESET;
    end else if (cfg.valid) begin
      buffer_words <= cfg.buffer_words;
    end
  end

  // Request stage. A beat is taken whenever no request is waiting to execute,
  // so a new request enters while an earlier result still waits to be taken.
  logic                         busy;
  logic [vrq_pkg::REQ_W-1:0]    item_req;
  logic [vrq_pkg::ID_W-1:0]     item_id;
  logic [vrq_pkg::LEN_W-1:0]    item_len;
  logic [vrq_pkg::WORD_W-1:0]   item_data;
  logic [vrq_pkg::LEN_W-1:0]    item_cap;
  logic                         accept;
  logic                         exec;
  logic                         res_valid;

  assign request.ready = !busy;
  assign accept        = request.valid && !busy;
  // A request executes once its memory read has returned and the result
  // register is free or being emptied in the same cycle.
  assign exec          = busy && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (exec) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_req  <= request.req_type;
      item_id   <= request.identifier;
      item_len  <= request.byte_length;
      item_data <= request.data_word;
      item_cap  <= request.pop_capacity;
    end
  end

  // Queue state.
  logic [POS_W-1:0] insert_position, insert_position_next;
  logic [POS_W-1:0] end_mark, end_mark_next;
  logic [POS_W-1:0] read_position, read_position_next;
  logic [POS_W-1:0] occupied_words, occupied_words_next;
  logic [POS_W-1:0] record_count, record_count_next;
  logic [POS_W-1:0] push_words_left, push_words_left_next;
  logic             push_active, push_active_next;
  logic [POS_W-1:0] pop_words_left, pop_words_left_next;
  logic             pop_active, pop_active_next;

  // Working copies of the open records: size, next word position and the
  // popped header, so that no header has to be read back from the ring.
  logic [POS_W-1:0]           push_size, push_size_next;
  logic [POS_W-1:0]           push_addr, push_addr_next;
  logic [POS_W-1:0]           pop_size, pop_size_next;
  logic [POS_W-1:0]           pop_addr, pop_addr_next;
  logic [vrq_pkg::ID_W-1:0]   pop_id, pop_id_next;
  logic [vrq_pkg::LEN_W-1:0]  pop_len, pop_len_next;

  // Ring memory: one write port used at execute, one registered read port
  // used when a request beat is taken.
  logic [vrq_pkg::WORD_W-1:0] ring_store [RING_DEPTH];
  logic [vrq_pkg::WORD_W-1:0] rdata;
  logic [POS_W-1:0]           rd_pos;
  logic                       mem_we;
  logic [POS_W-1:0]           wr_pos;
  logic [vrq_pkg::WORD_W-1:0] wdata;

  // Every request reads the word a pop would need: the next payload word of
  // an open pop, or else the header at the read position, which restarts at
  // word zero when it has reached the end mark. Writes of the previous request
  // land at its execute edge, before this read, so no forwarding is needed.
  always_comb begin
    if (pop_active) begin
      rd_pos = pop_addr;
    end else if (read_position == end_mark) begin
      rd_pos = '0;
    end else begin
      rd_pos = read_position;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= ring_store[ring_addr(rd_pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      ring_store[ring_addr(wr_pos)] <= wdata;
    end
  end

  // Push start placement.
  logic [vrq_pkg::SIZE_W-1:0] start_pw;
  logic [vrq_pkg::SIZE_W-1:0] start_size;
  vrq_pkg::place_t            place;

  assign start_pw   = vrq_pkg::payload_words(item_len);
  assign start_size = start_pw + vrq_pkg::SIZE_W'(1);

  vrq_space_check #(
    .RING_DEPTH(RING_DEPTH)
  ) u_space_check (
    .insert_position(insert_position),
    .end_mark       (end_mark),
    .read_position  (read_position),
    .occupied_words (occupied_words),
    .buffer_words   (buffer_words),
    .size           (start_size),
    .place          (place)
  );

  // Execute: one read-modify-write of the pointers per request.
  logic [vrq_pkg::STATUS_W-1:0] st;
  logic [vrq_pkg::ID_W-1:0]     oid;
  logic [vrq_pkg::LEN_W-1:0]    olen;
  logic [vrq_pkg::WORD_W-1:0]   oword;
  logic                         first;
  logic                         last;
  logic                         commit;
  logic [POS_W-1:0]             commit_base;
  logic [POS_W-1:0]             commit_size;
  logic [POS_W-1:0]             commit_end;
  logic                         free;
  logic [POS_W-1:0]             free_base;
  logic [POS_W-1:0]             free_size;
  logic [POS_W-1:0]             start_base;
  logic [POS_W-1:0]             pop_base;
  logic [vrq_pkg::LEN_W-1:0]    hdr_len;
  logic [vrq_pkg::SIZE_W-1:0]   hdr_pw;

  always_comb begin
    insert_position_next = insert_position;
    end_mark_next        = end_mark;
    read_position_next   = read_position;
    occupied_words_next  = occupied_words;
    record_count_next    = record_count;
    push_words_left_next = push_words_left;
    push_active_next     = push_active;
    pop_words_left_next  = pop_words_left;
    pop_active_next      = pop_active;
    push_size_next       = push_size;
    push_addr_next       = push_addr;
    pop_size_next        = pop_size;
    pop_addr_next        = pop_addr;
    pop_id_next          = pop_id;
    pop_len_next         = pop_len;

    st          = vrq_pkg::ST_OK;
    oid         = '0;
    olen        = '0;
    oword       = '0;
    first       = 1'b0;
    last        = 1'b0;
    mem_we      = 1'b0;
    wr_pos      = push_addr;
    wdata       = item_data;
    commit      = 1'b0;
    commit_base = insert_position;
    commit_size = push_size;
    commit_end  = '0;
    free        = 1'b0;
    free_base   = read_position;
    free_size   = pop_size;
    start_base  = place.wrap ? '0 : insert_position;
    pop_base    = (read_position == end_mark) ? '0 : read_position;
    hdr_len     = rdata[vrq_pkg::LEN_W-1:0];
    hdr_pw      = vrq_pkg::payload_words(hdr_len);

    unique case (item_req)
      vrq_pkg::REQ_PUSH_START: begin
        if (push_active) begin
          st = vrq_pkg::ST_SEQ_ERR;
        end else if (place.reject) begin
          st = vrq_pkg::ST_FULL;
        end else begin
          // An accepted size never exceeds the depth, so it fits a position.
          mem_we               = 1'b1;
          wr_pos               = start_base;
          wdata                = {item_id, item_len};
          insert_position_next = start_base;
          push_active_next     = 1'b1;
          push_words_left_next = POS_W'(start_pw);
          push_size_next       = POS_W'(start_size);
          push_addr_next       = start_base + POS_W'(1);
          if (start_pw == '0) begin
            commit      = 1'b1;
            commit_base = start_base;
            commit_size = POS_W'(start_size);
          end
        end
      end
      vrq_pkg::REQ_PUSH_DATA: begin
        if (!push_active) begin
          st = vrq_pkg::ST_SEQ_ERR;
        end else begin
          mem_we               = 1'b1;
          wr_pos               = push_addr;
          wdata                = item_data;
          push_addr_next       = push_addr + POS_W'(1);
          push_words_left_next = push_words_left - POS_W'(1);
          if (push_words_left == POS_W'(1)) begin
            commit = 1'b1;
          end
        end
      end
      vrq_pkg::REQ_POP: begin
        if (pop_active) begin
          oid                 = pop_id;
          olen                = pop_len;
          oword               = rdata;
          pop_addr_next       = pop_addr + POS_W'(1);
          pop_words_left_next = pop_words_left - POS_W'(1);
          if (pop_words_left == POS_W'(1)) begin
            last = 1'b1;
            free = 1'b1;
          end
        end else if ((record_count == '0) || (occupied_words == '0)) begin
          st = vrq_pkg::ST_EMPTY;
        end else begin
          // Header beat. Reaching the end mark moves the reader to word zero
          // and pulls the end mark down to the insert position.
          if (read_position == end_mark) begin
            end_mark_next = insert_position;
          end
          read_position_next = pop_base;
          oid                = rdata[vrq_pkg::WORD_W-1:vrq_pkg::LEN_W];
          first              = 1'b1;
          free_base          = pop_base;
          free_size          = POS_W'(hdr_pw) + POS_W'(1);
          if (item_cap < hdr_len) begin
            // Too large for the reader: the whole record is skipped.
            st   = vrq_pkg::ST_DROPPED;
            last = 1'b1;
            free = 1'b1;
          end else begin
            olen = hdr_len;
            if (hdr_pw == '0) begin
              last = 1'b1;
              free = 1'b1;
            end else begin
              pop_active_next     = 1'b1;
              pop_words_left_next = POS_W'(hdr_pw);
              pop_size_next       = POS_W'(hdr_pw) + POS_W'(1);
              pop_addr_next       = pop_base + POS_W'(1);
              pop_id_next         = rdata[vrq_pkg::WORD_W-1:vrq_pkg::LEN_W];
              pop_len_next        = hdr_len;
            end
          end
        end
      end
      vrq_pkg::REQ_CLEAR: begin
        insert_position_next = '0;
        end_mark_next        = '0;
        read_position_next   = '0;
        occupied_words_next  = '0;
        record_count_next    = '0;
        push_words_left_next = '0;
        push_active_next     = 1'b0;
        pop_words_left_next  = '0;
        pop_active_next      = 1'b0;
      end
      default: begin
        st = vrq_pkg::ST_OK;
      end
    endcase

    // The record becomes visible and takes its space on its last word.
    if (commit) begin
      commit_end           = commit_base + commit_size;
      record_count_next    = record_count + POS_W'(1);
      occupied_words_next  = occupied_words + commit_size;
      insert_position_next = commit_end;
      if (commit_end > end_mark) begin
        end_mark_next = commit_end;
      end
      push_active_next     = 1'b0;
      push_words_left_next = '0;
    end

    // The record's words are released with its last result.
    if (free) begin
      record_count_next   = record_count - POS_W'(1);
      occupied_words_next = occupied_words - free_size;
      read_position_next  = free_base + free_size;
      pop_active_next     = 1'b0;
      pop_words_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_position <= '0;
      end_mark        <= '0;
      read_position   <= '0;
      occupied_words  <= '0;
      record_count    <= '0;
      push_words_left <= '0;
      push_active     <= 1'b0;
      pop_words_left  <= '0;
      pop_active      <= 1'b0;
    end else if (exec) begin
      insert_position <= insert_position_next;
      end_mark        <= end_mark_next;
      read_position   <= read_position_next;
      occupied_words  <= occupied_words_next;
      record_count    <= record_count_next;
      push_words_left <= push_words_left_next;
      push_active     <= push_active_next;
      pop_words_left  <= pop_words_left_next;
      pop_active      <= pop_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      push_size <= push_size_next;
      push_addr <= push_addr_next;
      pop_size  <= pop_size_next;
      pop_addr  <= pop_addr_next;
      pop_id    <= pop_id_next;
      pop_len   <= pop_len_next;
    end
  end

  // Result register. It holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result.status          <= st;
      result.out_identifier  <= oid;
      result.out_length      <= olen;
      result.out_word        <= oword;
      result.first_of_record <= first;
      result.last_of_record  <= last;
      result.words_used      <= vrq_pkg::COUNT_W'(occupied_words_next);
      result.records_stored  <= vrq_pkg::COUNT_W'(record_count_next);
    end
  end

  assign result.valid = res_valid;

  // Every committed record holds at least its header word.
  a_count_le_words: assert property (@(posedge clk) disable iff (rst)
    record_count <= occupied_words)
    else $error("record count exceeds occupied words");

  // An open push always has words left, a closed one none.
  a_push_left: assert property (@(posedge clk) disable iff (rst)
    push_active == (push_words_left != '0))
    else $error("push word count disagrees with push state");

  // Likewise for an open pop.
  a_pop_left: assert property (@(posedge clk) disable iff (rst)
    pop_active == (pop_words_left != '0))
    else $error("pop word count disagrees with pop state");

  // A taken request beat always waits in the execute stage next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request lost before execute");

  // Execution always leaves a result in the output register.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> (res_valid && !busy))
    else $error("executed request produced no result");

endmodule

`default_nettype wire
